[src/btp_pkg.sv]
`default_nettype none
package btp_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int SCORE_WIDTH = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int ENTRY_W     = SCORE_WIDTH + TAG_WIDTH;
    localparam int KC_W        = 7;
    localparam int THR_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int SUM_W       = SCORE_WIDTH + THR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

    typedef logic signed [SCORE_WIDTH-1:0] t_score;
    typedef logic [TAG_WIDTH-1:0]          t_tag;

endpackage
`default_nettype wire

[src/beam_topk_threshold_prune_unit.sv]
`default_nettype none
// Collects hypotheses (score, tag) one per cycle while busy is low, storing them
// in a 64-entry RAM in arrival order; items beyond 64 are dropped but last still
// closes the set. After last, busy rises and survivors are emitted on o_res_strobe,
// one single-cycle word each, with rank and a final mark; the receiver cannot stall
// and every word must be taken when strobed. Output order is arrival order when
// no pruning applies, otherwise ascending score, stable on ties, found by a full
// RAM scan per survivor. The single RAM read port sets the emission time.
// Configuration writes are always ready and must be done while busy is low.
module beam_topk_threshold_prune_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [31:0]                i_score,
    input  wire logic [15:0]                       i_tag,
    input  wire logic                              i_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [btp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [btp_pkg::THR_W-1:0]         i_cfg_data,
    output logic                                   o_res_strobe,
    output logic signed [31:0]                     o_kept_score,
    output logic [15:0]                            o_kept_tag,
    output logic [5:0]                             o_rank,
    output logic                                   o_final_res
);
    import btp_pkg::*;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DEC   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_m, n_m;
    logic              r_sorted, n_sorted;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic              r_dv, n_dv;
    logic [ADDR_W-1:0] r_didx, n_didx;
    logic              r_bvalid, n_bvalid;
    t_score            r_bscore, n_bscore;
    t_tag              r_btag, n_btag;
    logic [ADDR_W-1:0] r_bidx, n_bidx;
    t_score            r_pscore, n_pscore;
    t_tag              r_ptag, n_ptag;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    t_score            r_limit, n_limit;
    logic [KC_W-1:0]   r_kc;
    logic              r_thr_en;
    logic [THR_W-1:0]  r_thr;
    logic              r_strobe, n_strobe;
    logic signed [31:0] r_o_score, n_o_score;
    logic [15:0]       r_o_tag, n_o_tag;
    logic [5:0]        r_o_rank, n_o_rank;
    logic              r_o_final, n_o_final;

    logic               accept;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    t_score             d_score;
    t_tag               d_tag;
    logic               after_prev;
    logic               before_best;
    logic               take;
    logic               issue;
    logic               qual;
    logic [CNT_W-1:0]   fill_inc;
    logic [KC_W-1:0]    kc_eff;
    logic [KC_W-1:0]    n_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] max_ext;

    assign busy         = (r_state != S_LOAD);
    assign o_cfg_ready  = 1'b1;
    assign accept       = start && !busy;
    assign wr_en        = accept && (r_fill < CNT_W'(MAX_ITEMS));
    assign wr_data      = {SCORE_WIDTH'(i_score), i_tag};
    assign d_score      = t_score'(rd_data[ENTRY_W-1:TAG_WIDTH]);
    assign d_tag        = rd_data[TAG_WIDTH-1:0];
    assign fill_inc     = wr_en ? r_fill + 1'b1 : r_fill;
    assign kc_eff       = (r_kc == '0) ? KC_W'(1) : r_kc;
    assign n_ext        = KC_W'(fill_inc);
    assign after_prev   = (r_cnt == '0) || (d_score > r_pscore) ||
                          ((d_score == r_pscore) && (r_didx > r_pidx));
    assign before_best  = !r_bvalid || (d_score < r_bscore);
    assign take         = r_dv && (!r_sorted || (after_prev && before_best));
    assign issue        = (r_rd <= CNT_W'(r_hi));
    assign qual         = r_bvalid &&
                          ((r_cnt == '0) || !r_thr_en || (r_bscore <= r_limit));
    assign sum          = SUM_W'(r_bscore) + SUM_W'($signed({1'b0, r_thr}));
    assign max_ext      = SUM_W'($signed({1'b0, {(SCORE_WIDTH-1){1'b1}}}));

    btp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_rd[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_n       = r_n;
        n_m       = r_m;
        n_sorted  = r_sorted;
        n_cnt     = r_cnt;
        n_rd      = r_rd;
        n_hi      = r_hi;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_bvalid  = r_bvalid;
        n_bscore  = r_bscore;
        n_btag    = r_btag;
        n_bidx    = r_bidx;
        n_pscore  = r_pscore;
        n_ptag    = r_ptag;
        n_pidx    = r_pidx;
        n_limit   = r_limit;
        n_strobe  = 1'b0;
        n_o_score = 32'(r_pscore);
        n_o_tag   = r_ptag;
        n_o_rank  = 6'(r_cnt - 1'b1);
        n_o_final = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    n_fill = fill_inc;
                    if (i_last) begin
                        n_fill   = '0;
                        n_n      = fill_inc;
                        n_sorted = (n_ext > kc_eff) || r_thr_en;
                        n_m      = (n_ext > kc_eff) ? CNT_W'(kc_eff) : fill_inc;
                        n_cnt    = '0;
                        n_state  = S_START;
                    end
                end
            end
            S_START: begin
                if (r_cnt < r_m) begin
                    n_rd     = r_sorted ? '0 : r_cnt;
                    n_hi     = r_sorted ? ADDR_W'(r_n - 1'b1) : r_cnt[ADDR_W-1:0];
                    n_bvalid = 1'b0;
                    n_state  = S_SCAN;
                end else begin
                    n_strobe  = 1'b1;
                    n_o_final = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd = r_rd + 1'b1;
                end
                n_dv   = issue;
                n_didx = r_rd[ADDR_W-1:0];
                if (take) begin
                    n_bvalid = 1'b1;
                    n_bscore = d_score;
                    n_btag   = d_tag;
                    n_bidx   = r_didx;
                end
                if (r_dv && (r_didx == r_hi)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (qual) begin
                    n_strobe = (r_cnt != '0);
                    n_pscore = r_bscore;
                    n_ptag   = r_btag;
                    n_pidx   = r_bidx;
                    n_cnt    = r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        n_limit = (sum > max_ext) ? t_score'(max_ext[SCORE_WIDTH-1:0])
                                                  : t_score'(sum[SCORE_WIDTH-1:0]);
                    end
                    n_state = S_START;
                end else begin
                    n_strobe  = 1'b1;
                    n_o_final = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_dv     <= 1'b0;
            r_bvalid <= 1'b0;
            r_strobe <= 1'b0;
            r_kc     <= KC_W'(1);
            r_thr_en <= 1'b0;
            r_thr    <= '1;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_dv     <= n_dv;
            r_bvalid <= n_bvalid;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEEP_COUNT: r_kc     <= i_cfg_data[KC_W-1:0];
                    CFG_THR_ENABLE: r_thr_en <= i_cfg_data[0];
                    CFG_THRESHOLD:  r_thr    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_m       <= n_m;
        r_sorted  <= n_sorted;
        r_rd      <= n_rd;
        r_hi      <= n_hi;
        r_didx    <= n_didx;
        r_bscore  <= n_bscore;
        r_btag    <= n_btag;
        r_bidx    <= n_bidx;
        r_pscore  <= n_pscore;
        r_ptag    <= n_ptag;
        r_pidx    <= n_pidx;
        r_limit   <= n_limit;
        r_o_score <= n_o_score;
        r_o_tag   <= n_o_tag;
        r_o_rank  <= n_o_rank;
        r_o_final <= n_o_final;
    end

    assign o_res_strobe = r_strobe;
    assign o_kept_score = r_o_score;
    assign o_kept_tag   = r_o_tag;
    assign o_rank       = r_o_rank;
    assign o_final_res  = r_o_final;

endmodule
`default_nettype wire

[src/btp_ram.sv]
`default_nettype none
module btp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
